@@ src/rrtt_pkg.sv @@
// Shared types and constants for the request retry/timeout table.
// No dependencies; imported by every module of the block.
`default_nettype none
package rrtt_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LIVE_W = $clog2(TABLE_DEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
    localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [1:0] CFG_ID_FROM_CNT = 2'd2;

    // Input actions.
    localparam logic [1:0] ACT_ISSUE    = 2'd0;
    localparam logic [1:0] ACT_RESPONSE = 2'd1;
    localparam logic [1:0] ACT_WAKEUP   = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_ISSUED    = 3'd0;
    localparam logic [2:0] KIND_REPLY     = 3'd1;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd2;
    localparam logic [2:0] KIND_RESEND    = 3'd3;
    localparam logic [2:0] KIND_TIMED_OUT = 3'd4;
    localparam logic [2:0] KIND_WAKE_DONE = 3'd5;
    localparam logic [2:0] KIND_FULL      = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_RESP,
        ST_WAKE,
        ST_FINAL
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic inc_idx;
        logic probe_inc;
        logic issue_write;
        logic free_match;
        logic wake_wait;
        logic wake_emit;
        logic emit_final;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_action;
        logic       full;
        logic       idx_last;
        logic       match;
        logic       need_emit;
        logic       out_free;
    } status_t;
endpackage
`default_nettype wire

@@ src/rrtt_ctrl.sv @@
// Controller state machine for the request table: sequences issue probes,
// response lookups and wakeup scans. Depends on rrtt_pkg.
`default_nettype none
module rrtt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rrtt_pkg::status_t status,
    output rrtt_pkg::cmd_t       cmd
);
    import rrtt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (status.in_action)
                        ACT_ISSUE:    state_next = status.full ? ST_FINAL : ST_ISSUE;
                        ACT_RESPONSE: state_next = ST_RESP;
                        ACT_WAKEUP:   state_next = ST_WAKE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                if (!status.match && status.idx_last)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_RESP:
            begin
                if (status.match || status.idx_last)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_WAKE:
            begin
                if (status.idx_last && (!status.need_emit || status.out_free))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ISSUE:
            begin
                if (status.match)
                begin
                    cmd.probe_inc = 1'b1;
                end
                else if (status.idx_last)
                begin
                    cmd.issue_write = 1'b1;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                end
            end
            ST_RESP:
            begin
                if (status.match)
                begin
                    cmd.free_match = 1'b1;
                end
                else
                begin
                    cmd.inc_idx = !status.idx_last;
                end
            end
            ST_WAKE:
            begin
                if (!status.need_emit)
                begin
                    cmd.wake_wait = 1'b1;
                    cmd.inc_idx   = !status.idx_last;
                end
                else if (status.out_free)
                begin
                    cmd.wake_emit = 1'b1;
                    cmd.inc_idx   = !status.idx_last;
                end
            end
            ST_FINAL:
            begin
                cmd.emit_final = status.out_free;
            end
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ src/rrtt_dp.sv @@
// Datapath for the request table: entry storage, configuration registers,
// item registers, scan index and the output register. Depends on rrtt_pkg.
`default_nettype none
module rrtt_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    input  wire logic [87:0]   in_data,
    input  wire rrtt_pkg::cmd_t cmd,
    output rrtt_pkg::status_t  status,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [71:0]        out_data,
    output logic               out_last
);
    import rrtt_pkg::*;

    // Configuration registers.
    logic [15:0] timeout_reg;
    logic [7:0]  max_retries_reg;
    logic        id_from_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= 16'd1000;
            max_retries_reg <= 8'd0;
            id_from_cnt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT:     timeout_reg     <= cfg_data;
                CFG_MAX_RETRIES: max_retries_reg <= cfg_data[7:0];
                CFG_ID_FROM_CNT: id_from_cnt_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Input fields.
    logic [1:0]  in_action;
    logic [31:0] in_req;
    logic [31:0] in_now;
    logic        in_fx;
    logic [15:0] in_tag;
    assign in_action = in_data[1:0];
    assign in_req    = in_data[33:2];
    assign in_now    = in_data[65:34];
    assign in_fx     = in_data[66];
    assign in_tag    = in_data[82:67];

    // Entry table.
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [31:0] ent_id_reg      [TABLE_DEPTH];
    logic [7:0]  ent_retries_reg [TABLE_DEPTH];
    logic [31:0] ent_sent_reg    [TABLE_DEPTH];
    logic [15:0] ent_tag_reg     [TABLE_DEPTH];
    logic [LIVE_W-1:0] live_reg, live_next;

    // Item and scan registers.
    logic [31:0] now_reg;
    logic        fx_reg;
    logic [15:0] tag_reg;
    logic [31:0] probe_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0] wait_reg, wait_next;
    logic [2:0]  res_kind_reg;
    logic [31:0] res_ref_reg;
    logic [15:0] res_tag_reg;

    // Lowest free slot.
    logic [IDX_W-1:0] free_idx;
    always_comb
    begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Current entry tests.
    logic [31:0] elapsed;
    logic        expired;
    logic [15:0] remain;
    logic        cur_valid;
    assign cur_valid = valid_reg[idx_reg];
    assign elapsed   = now_reg - ent_sent_reg[idx_reg];
    assign expired   = {16'd0, timeout_reg} <= elapsed;
    assign remain    = timeout_reg - elapsed[15:0];

    logic retry_ok;
    assign retry_ok = ent_retries_reg[idx_reg] < max_retries_reg;

    assign status.in_action = in_action;
    assign status.full      = &valid_reg;
    assign status.idx_last  = idx_reg == IDX_W'(TABLE_DEPTH - 1);
    assign status.match     = cur_valid && (ent_id_reg[idx_reg] == probe_reg);
    assign status.need_emit = cur_valid && expired && fx_reg;
    assign status.out_free  = !out_valid || out_ready;

    // Minimum wait update; a zero candidate does not count.
    function automatic logic [15:0] min_wait(input logic [15:0] cur, input logic [15:0] cand);
        logic [15:0] r;
        r = cur;
        if (cand != 16'd0 && (cur == 16'd0 || cand < cur))
        begin
            r = cand;
        end
        return r;
    endfunction

    always_comb
    begin
        wait_next = wait_reg;
        live_next = live_reg;
        if (cmd.load)
        begin
            wait_next = '0;
        end
        if (cmd.wake_wait && cur_valid && !expired)
        begin
            wait_next = min_wait(wait_reg, remain);
        end
        if (cmd.wake_emit && retry_ok)
        begin
            wait_next = min_wait(wait_reg, timeout_reg);
        end
        if (cmd.issue_write)
        begin
            live_next = live_reg + 1'b1;
        end
        if (cmd.free_match || (cmd.wake_emit && !retry_ok))
        begin
            live_next = live_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            live_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            live_reg <= live_next;
            if (cmd.load || cmd.probe_inc)
            begin
                idx_reg <= '0;
            end
            else if (cmd.inc_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.issue_write)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.free_match || (cmd.wake_emit && !retry_ok))
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Entry payload and item registers.
    always_ff @(posedge clk)
    begin
        wait_reg <= wait_next;
        if (cmd.load)
        begin
            now_reg   <= in_now;
            fx_reg    <= in_fx;
            tag_reg   <= in_tag;
            probe_reg <= (in_action == ACT_ISSUE && id_from_cnt_reg) ?
                         32'(live_reg) : in_req;
            res_ref_reg <= '0;
            res_tag_reg <= '0;
            case (in_action)
                ACT_RESPONSE:
                begin
                    res_kind_reg <= KIND_UNKNOWN;
                    res_ref_reg  <= in_req;
                end
                ACT_WAKEUP: res_kind_reg <= KIND_WAKE_DONE;
                default:    res_kind_reg <= KIND_FULL;
            endcase
        end
        if (cmd.probe_inc)
        begin
            probe_reg <= probe_reg + 32'd1;
        end
        if (cmd.issue_write)
        begin
            ent_id_reg[free_idx]      <= probe_reg;
            ent_retries_reg[free_idx] <= '0;
            ent_sent_reg[free_idx]    <= now_reg;
            ent_tag_reg[free_idx]     <= tag_reg;
            res_kind_reg <= KIND_ISSUED;
            res_ref_reg  <= probe_reg;
            res_tag_reg  <= tag_reg;
        end
        if (cmd.free_match)
        begin
            res_kind_reg <= KIND_REPLY;
            res_tag_reg  <= ent_tag_reg[idx_reg];
        end
        if (cmd.wake_emit && retry_ok)
        begin
            ent_retries_reg[idx_reg] <= ent_retries_reg[idx_reg] + 8'd1;
            ent_sent_reg[idx_reg]    <= now_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.wake_emit || cmd.emit_final)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wake_emit)
        begin
            out_data <= {live_next, 16'd0, ent_tag_reg[idx_reg],
                         ent_id_reg[idx_reg],
                         retry_ok ? KIND_RESEND : KIND_TIMED_OUT};
            out_last <= 1'b0;
        end
        else if (cmd.emit_final)
        begin
            out_data <= {live_next, wait_reg, res_tag_reg, res_ref_reg, res_kind_reg};
            out_last <= 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ src/request_retry_timeout_table.sv @@
// Top level of the outstanding-request table with retry and timeout.
// Instantiates rrtt_ctrl and rrtt_dp; depends on rrtt_pkg.
//
//  port group   dir  beat contents
//  s_axis_*     in   one request: issue, response or wakeup scan
//  m_axis_*     out  one result; tlast marks the final result of a request
//  cfg_*        in   register write, no handshake
//
// One request at a time. Every request is accepted in the idle state, then: issue
// scans the table for each probed id (one slot per cycle), response scans until
// it finds the id or reaches the last slot, wakeup scans every slot and waits out
// output stalls; then the final result is sent. A full-table issue goes to it at once.
// Reset clears the valid bits and live count at once. The wakeup scan pauses at
// an entry that needs a beat while the output register holds an untaken beat.
`default_nettype none
module request_retry_timeout_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action[1:0], request_id[33:2], now_ms[65:34], side_effects[66],
    // payload_tag[82:67], zero[87:83]
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // kind[2:0], entry_ref[34:3], tag_out[50:35], next_wakeup_ms[66:51],
    // outstanding[71:67]
    output logic [71:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import rrtt_pkg::*;

    cmd_t    cmd;
    status_t status;

    rrtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrtt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );
endmodule
`default_nettype wire

@@ tb/tb_request_retry_timeout_table.sv @@
// Self-checking testbench for request_retry_timeout_table: issues, responses and
// wakeup scans are predicted in a behavioral table model and compared beat by beat.
// Depends on rrtt_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_request_retry_timeout_table;
    import rrtt_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] ref_id;
        logic [15:0] tag;
        logic [15:0] wait_ms;
        logic [4:0]  live;
        logic        tlast;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    request_retry_timeout_table dut (.*);

    always #2 clk = ~clk;

    // Predictor state.
    logic [15:0] p_timeout;
    logic [7:0]  p_max_retries;
    logic        p_id_from_count;
    logic        tbl_valid [TABLE_DEPTH];
    logic [31:0] tbl_id    [TABLE_DEPTH];
    logic [7:0]  tbl_retry [TABLE_DEPTH];
    logic [31:0] tbl_sent  [TABLE_DEPTH];
    logic [15:0] tbl_tag   [TABLE_DEPTH];
    logic [4:0]  tbl_live;

    result_t expected_results[$];
    int      errors = 0;
    int      n_items = 0;
    int      n_results = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_cycles = 0;
    longint  cycle = 0;

    // Live ids, kept so stimulus can aim responses at real entries.
    function automatic logic [31:0] pick_live_id();
        int k;
        k = $urandom_range(TABLE_DEPTH - 1);
        for (int n = 0; n < TABLE_DEPTH; n++)
            if (tbl_valid[(k + n) % TABLE_DEPTH])
                return tbl_id[(k + n) % TABLE_DEPTH];
        return $urandom;
    endfunction

    function automatic int find_live(logic [31:0] id);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i] && tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [31:0] id, logic [15:0] tag,
                                        logic [15:0] wt, logic tl);
        result_t r;
        r.kind = kind; r.ref_id = id; r.tag = tag; r.wait_ms = wt;
        r.live = tbl_live; r.tlast = tl;
        expected_results.push_back(r);
    endfunction

    function automatic logic [31:0] shorter_wait(logic [31:0] cur, logic [31:0] cand);
        if (cand == 0) return cur;
        if (cur == 0 || cand < cur) return cand;
        return cur;
    endfunction

    // Table behavior for one accepted request.
    function automatic void predict_request(logic [1:0] act, logic [31:0] rid,
                                            logic [31:0] now, logic fx, logic [15:0] tag);
        int slot;
        logic [31:0] id, elapsed, wt;
        slot = -1;
        wt = 0;
        case (act)
            ACT_ISSUE:
            begin
                for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                    if (!tbl_valid[i]) slot = i;
                if (slot < 0)
                begin
                    push_result(KIND_FULL, 0, 0, 0, 1'b1);
                    return;
                end
                id = p_id_from_count ? 32'(tbl_live) : rid;
                while (find_live(id) >= 0) id = id + 1;
                tbl_valid[slot] = 1'b1; tbl_id[slot] = id; tbl_retry[slot] = 0;
                tbl_sent[slot] = now; tbl_tag[slot] = tag;
                tbl_live++;
                push_result(KIND_ISSUED, id, tag, 0, 1'b1);
            end
            ACT_RESPONSE:
            begin
                slot = find_live(rid);
                if (slot < 0)
                    push_result(KIND_UNKNOWN, rid, 0, 0, 1'b1);
                else
                begin
                    tbl_valid[slot] = 1'b0;
                    tbl_live--;
                    push_result(KIND_REPLY, rid, tbl_tag[slot], 0, 1'b1);
                end
            end
            ACT_WAKEUP:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!tbl_valid[i]) continue;
                    elapsed = now - tbl_sent[i];
                    if (32'(p_timeout) <= elapsed)
                    begin
                        if (!fx) continue;
                        if (tbl_retry[i] < p_max_retries)
                        begin
                            tbl_retry[i]++;
                            tbl_sent[i] = now;
                            wt = shorter_wait(wt, 32'(p_timeout));
                            push_result(KIND_RESEND, tbl_id[i], tbl_tag[i], 0, 1'b0);
                        end
                        else
                        begin
                            tbl_valid[i] = 1'b0;
                            tbl_live--;
                            push_result(KIND_TIMED_OUT, tbl_id[i], tbl_tag[i], 0, 1'b0);
                        end
                    end
                    else
                        wt = shorter_wait(wt, 32'(p_timeout) - elapsed);
                end
                push_result(KIND_WAKE_DONE, 0, 0, wt[15:0], 1'b1);
            end
            default: ;
        endcase
    endfunction

    // Send one request beat, with random idle cycles ahead of it. The valid
    // stays up after acceptance until the next beat, an idle cycle or a drain.
    task automatic send_request(logic [1:0] act, logic [31:0] rid, logic [31:0] now,
                                logic fx, logic [15:0] tag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, tag, fx, now, rid, act};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_request(act, rid, now, fx, tag);
        n_items++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TIMEOUT:     p_timeout = value;
            CFG_MAX_RETRIES: p_max_retries = value[7:0];
            CFG_ID_FROM_CNT: p_id_from_count = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [15:0] tmo, logic [7:0] retries, logic from_cnt);
        wait_drained();
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MAX_RETRIES, {8'd0, retries});
        write_reg(CFG_ID_FROM_CNT, {15'd0, from_cnt});
    endtask

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[50:35],
                   m_axis_tdata[66:51], m_axis_tdata[71:67], m_axis_tlast};
            n_results++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.kind != want.kind)
                begin
                    errors++;
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                end
                if (got.ref_id != want.ref_id)
                begin
                    errors++;
                    $display("%0t: entry_ref expected %h actual %h", $time, want.ref_id, got.ref_id);
                end
                if (got.tag != want.tag)
                begin
                    errors++;
                    $display("%0t: tag_out expected %h actual %h", $time, want.tag, got.tag);
                end
                if (got.wait_ms != want.wait_ms)
                begin
                    errors++;
                    $display("%0t: next_wakeup_ms expected %0d actual %0d", $time,
                             want.wait_ms, got.wait_ms);
                end
                if (got.live != want.live)
                begin
                    errors++;
                    $display("%0t: outstanding expected %0d actual %0d", $time, want.live, got.live);
                end
                if (got.tlast != want.tlast)
                begin
                    errors++;
                    $display("%0t: tlast expected %0b actual %0b", $time, want.tlast, got.tlast);
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
        if (cycle > 1500000)
        begin
            $display("Mismatches found");
            $finish;
        end

    // Directed: fill to full, probe past used ids with wrap, replies, unknowns,
    // wakeups with and without side effects, unused action.
    task automatic test_directed();
        send_request(ACT_ISSUE, 32'hFFFF_FFFF, 0, 1'b0, 16'hFFFF);
        send_request(ACT_ISSUE, 32'hFFFF_FFFF, 0, 1'b1, 16'h0000);
        send_request(ACT_ISSUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'h5A5A);
        for (int i = 0; i < 13; i++)
            send_request(ACT_ISSUE, 32'd0, 32'(i), 1'b0, 16'(i));
        send_request(ACT_ISSUE, 32'd7, 0, 1'b0, 16'h1234);
        send_request(ACT_WAKEUP, 0, 500, 1'b1, 0);
        send_request(ACT_WAKEUP, 0, 32'h8000_0000, 1'b0, 0);
        send_request(2'd3, 32'hFFFF_FFFF, 0, 1'b1, 16'hFFFF);
        send_request(ACT_RESPONSE, 32'hFFFF_FFFF, 0, 1'b0, 0);
        send_request(ACT_RESPONSE, 32'hDEAD_BEEF, 0, 1'b0, 0);
        send_request(ACT_WAKEUP, 0, 5000, 1'b1, 0);
        send_request(ACT_WAKEUP, 0, 5000, 1'b1, 0);
    endtask

    task automatic random_request();
        int r;
        logic [31:0] base;
        r = $urandom_range(99);
        base = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40));
        if (r < 45)
            send_request(ACT_ISSUE, ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20)),
                         base, $urandom_range(1), $urandom);
        else if (r < 70)
            send_request(ACT_RESPONSE, ($urandom_range(4) == 0) ? $urandom : pick_live_id(),
                         $urandom, $urandom_range(1), $urandom);
        else if (r < 97)
            send_request(ACT_WAKEUP, $urandom, base + 32'($urandom_range(3000)),
                         ($urandom_range(4) != 0), $urandom);
        else
            send_request(2'd3, $urandom, $urandom, $urandom_range(1), $urandom);
    endtask

    task automatic test_random(int count);
        repeat (count) random_request();
    endtask

    // Long output hold-off while requests keep coming, then a full pause.
    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (20) random_request();
        wait_drained();
        repeat (10) random_request();
    endtask

    initial
    begin
        p_timeout = 16'd1000; p_max_retries = 0; p_id_from_count = 0; tbl_live = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22; recv_idle_pct = 69;
        test_directed();
        configure(16'd0, 8'd0, 1'b0);
        send_request(ACT_WAKEUP, 0, 0, 1'b1, 0);
        configure(16'd1, 8'd255, 1'b1);
        test_random(70);
        configure(16'd65535, 8'd2, 1'b0);
        test_random(70);

        send_idle_pct = 69; recv_idle_pct = 22;
        configure(16'd500, 8'd1, 1'b1);
        test_random(80);
        configure(16'd1000, 8'd0, 1'b0);
        test_random(80);

        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        configure(16'd2000, 8'd3, 1'b0);
        test_random(110);
        wait_drained();

        $display("Sent %0d requests and checked %0d result beats over several register settings.",
                 n_items, n_results);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
